// ===== sv/cpo_pkg.sv =====
`default_nettype none

package cpo_pkg;

    // Field widths of the coordinate stream and the register.
    localparam int COORD_W = 20;
    localparam int SEP_W   = 16;

    // Datapath widths: difference, square and sum, root, product, quotient, divisor, dividend and move.
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int PROD_W = DIFF_W + SEP_W;
    localparam int Q_W    = SEP_W;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int NUM_W  = DEN_W + Q_W;
    localparam int MV_W   = Q_W + 1;

    localparam int COORD_FRAC_BITS_DEF = 8;

    localparam logic [SEP_W-1:0] SEP_RESET = 16'd10240;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Lane order of the four moves: target x and y, then position x and y.
    localparam int LN_GX = 0;
    localparam int LN_GY = 1;
    localparam int LN_AX = 2;
    localparam int LN_AY = 3;

    // Pass order of the two roots.
    localparam int PS_GOAL = 0;
    localparam int PS_AT   = 1;

    // Coordinate order inside a request: targets, then positions.
    localparam int CO_FGX = 0;
    localparam int CO_FGY = 1;
    localparam int CO_SGX = 2;
    localparam int CO_SGY = 3;
    localparam int CO_FAX = 4;
    localparam int CO_FAY = 5;
    localparam int CO_SAX = 6;
    localparam int CO_SAY = 7;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Data carried alongside the square root unit.
    typedef struct packed {
        logic [7:0][COORD_W-1:0] orig;
        logic [3:0][DIFF_W-1:0]  dmag;
        logic [3:0]              neg;
        logic                    ovl_g;
        logic                    ovl_a;
        logic                    near_g;
        logic                    near_a;
        logic                    zero_a;
    } t_sqrt_side;

    // Data carried alongside the divider.
    typedef struct packed {
        logic [7:0][COORD_W-1:0] orig;
        logic [3:0]              neg;
        logic                    ovl_g;
        logic                    plusx_g;
        logic                    ovl_a;
        logic                    plusx_a;
        logic [1:0][SEP_W-1:0]   sf;
    } t_div_side;

    // Clamp a widened sum into the coordinate range.
    function automatic t_coord sat_coord(input logic signed [COORD_W:0] v);
        t_coord res;
        if (v > $signed({COORD_MAX[COORD_W-1], COORD_MAX})) begin
            res = COORD_MAX;
        end else if (v < $signed({COORD_MIN[COORD_W-1], COORD_MIN})) begin
            res = COORD_MIN;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpo_if.sv =====
`default_nettype none

// Request channel: the two circles of one pair.
interface cpo_req_if;
    logic valid;
    logic ready;
    logic signed [cpo_pkg::COORD_W-1:0] first_goal_x;
    logic signed [cpo_pkg::COORD_W-1:0] first_goal_y;
    logic signed [cpo_pkg::COORD_W-1:0] second_goal_x;
    logic signed [cpo_pkg::COORD_W-1:0] second_goal_y;
    logic signed [cpo_pkg::COORD_W-1:0] first_at_x;
    logic signed [cpo_pkg::COORD_W-1:0] first_at_y;
    logic signed [cpo_pkg::COORD_W-1:0] second_at_x;
    logic signed [cpo_pkg::COORD_W-1:0] second_at_y;

    modport source (output valid, first_goal_x, first_goal_y, second_goal_x, second_goal_y,
                    first_at_x, first_at_y, second_at_x, second_at_y, input ready);
    modport sink (input valid, first_goal_x, first_goal_y, second_goal_x, second_goal_y,
                  first_at_x, first_at_y, second_at_x, second_at_y, output ready);
endinterface

// Result channel: the separated pair.
interface cpo_res_if;
    logic valid;
    logic ready;
    logic signed [cpo_pkg::COORD_W-1:0] new_first_goal_x;
    logic signed [cpo_pkg::COORD_W-1:0] new_first_goal_y;
    logic signed [cpo_pkg::COORD_W-1:0] new_second_goal_x;
    logic signed [cpo_pkg::COORD_W-1:0] new_second_goal_y;
    logic signed [cpo_pkg::COORD_W-1:0] new_first_at_x;
    logic signed [cpo_pkg::COORD_W-1:0] new_first_at_y;
    logic signed [cpo_pkg::COORD_W-1:0] new_second_at_x;
    logic signed [cpo_pkg::COORD_W-1:0] new_second_at_y;

    modport source (output valid, new_first_goal_x, new_first_goal_y, new_second_goal_x,
                    new_second_goal_y, new_first_at_x, new_first_at_y, new_second_at_x,
                    new_second_at_y, input ready);
    modport sink (input valid, new_first_goal_x, new_first_goal_y, new_second_goal_x,
                  new_second_goal_y, new_first_at_x, new_first_at_y, new_second_at_x,
                  new_second_at_y, output ready);
endinterface

// Register write channel.
interface cpo_cfg_if;
    logic valid;
    logic ready;
    logic [cpo_pkg::SEP_W-1:0] min_separation;

    modport source (output valid, min_separation, input ready);
    modport sink (input valid, min_separation, output ready);
endinterface

`default_nettype wire

// ===== sv/circle_pair_overlap_separation.sv =====
// Circle pair overlap separation.
// A request on i_req carries two circles, each as a target point and a current
// position in signed fixed point. The result on o_res holds both pairs after
// overlapping circles are pushed apart by half the shortfall each, first the
// targets, then the positions; every coordinate saturates to its 20-bit range.
// i_cfg writes min_separation (sum of both radii); it is always ready. The user must
// write it only while no request is in flight; the block does not enforce this.
// Throughput: one request per clock cycle while the pipeline advances. The stages are
// the 21-step square root pipeline, the 16-step divider and ten arithmetic stages
// around them, the first of which is loaded at the accepting edge itself.
// The whole pipeline moves as one: it advances whenever the output register is
// empty or being taken. When the receiver holds o_res.ready low with a result
// waiting, i_req.ready falls and every stage holds its contents.
// Reset empties the pipeline and sets min_separation to 40 pixels (10240).
`default_nettype none

module circle_pair_overlap_separation #(
    parameter int COORD_FRAC_BITS = cpo_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpo_req_if.sink    i_req,
    cpo_res_if.source  o_res,
    cpo_cfg_if.sink    i_cfg
);

    localparam int COORD_W = cpo_pkg::COORD_W;
    localparam int SEP_W   = cpo_pkg::SEP_W;
    localparam int DIFF_W  = cpo_pkg::DIFF_W;
    localparam int SQ_W    = cpo_pkg::SQ_W;
    localparam int ROOT_W  = cpo_pkg::ROOT_W;
    localparam int PROD_W  = cpo_pkg::PROD_W;
    localparam int Q_W     = cpo_pkg::Q_W;
    localparam int DEN_W   = cpo_pkg::DEN_W;
    localparam int NUM_W   = cpo_pkg::NUM_W;
    localparam int MV_W    = cpo_pkg::MV_W;
    localparam int SQS_W   = $bits(cpo_pkg::t_sqrt_side);
    localparam int DVS_W   = $bits(cpo_pkg::t_div_side);

    // Largest squared distance that still counts as coincident (0.001 px).
    localparam logic [63:0] NEAR_LIMIT = (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd1000000;

    logic w_adv;

    logic [SEP_W-1:0] r_sep;

    logic                          r_v1;
    logic [7:0][COORD_W-1:0]       r1_orig;
    logic [3:0][DIFF_W-1:0]        r1_d;
    logic                          r_v2;
    cpo_pkg::t_sqrt_side           r2_side;
    logic                          r_v3;
    cpo_pkg::t_sqrt_side           r3_side;
    logic [3:0][SQ_W-1:0]          r3_sq;
    logic [2*SEP_W-1:0]            r3_sep2;
    logic                          r_v4;
    cpo_pkg::t_sqrt_side           r4_side;
    logic [1:0][SQ_W-1:0]          r4_s;
    logic [2*SEP_W-1:0]            r4_sep2;
    logic                          r_v5;
    cpo_pkg::t_sqrt_side           r5_side;
    logic [1:0][SQ_W-1:0]          r5_s;

    logic                          w_sq_vld;
    logic [SQS_W-1:0]              w_sq_side_bits;
    cpo_pkg::t_sqrt_side           w_sq_side;
    logic [1:0][ROOT_W-1:0]        w_root;

    logic                          r_v6;
    cpo_pkg::t_div_side            r6_side;
    logic [3:0][DIFF_W-1:0]        r6_mag;
    logic [1:0][ROOT_W-1:0]        r6_r;
    cpo_pkg::t_div_side            n6_side;
    logic [3:0][DIFF_W-1:0]        n6_mag;
    logic [1:0][ROOT_W-1:0]        n6_r;
    logic                          r_v7;
    cpo_pkg::t_div_side            r7_side;
    logic [3:0][PROD_W-1:0]        r7_prod;
    logic [1:0][ROOT_W-1:0]        r7_r;
    logic                          r_v8;
    cpo_pkg::t_div_side            r8_side;
    logic [3:0][NUM_W-1:0]         r8_num;
    logic [3:0][DEN_W-1:0]         r8_den;

    logic                          w_dv_vld;
    logic [DVS_W-1:0]              w_dv_side_bits;
    cpo_pkg::t_div_side            w_dv_side;
    logic [3:0][Q_W-1:0]           w_quo;

    logic                          r_v9;
    logic [7:0][COORD_W-1:0]       r9_orig;
    logic [3:0][MV_W-1:0]          r9_mv;
    logic [3:0][MV_W-1:0]          n9_mv;
    logic                          r_v10;
    logic [7:0][COORD_W-1:0]       r10_out;
    logic [7:0][COORD_W-1:0]       n10_out;

    // The pipeline moves whenever the output register can take a new result.
    assign w_adv       = !r_v10 || o_res.ready;
    assign i_req.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    // Separation register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= cpo_pkg::SEP_RESET;
        end else if (i_cfg.valid) begin
            r_sep <= i_cfg.min_separation;
        end
    end

    // Valid bits of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (w_adv) begin
            r_v1  <= i_req.valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= w_sq_vld;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= w_dv_vld;
            r_v10 <= r_v9;
        end
    end

    // Stages one to five: differences, magnitudes, squares, sums and flags.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_orig[cpo_pkg::CO_FGX] <= i_req.first_goal_x;
            r1_orig[cpo_pkg::CO_FGY] <= i_req.first_goal_y;
            r1_orig[cpo_pkg::CO_SGX] <= i_req.second_goal_x;
            r1_orig[cpo_pkg::CO_SGY] <= i_req.second_goal_y;
            r1_orig[cpo_pkg::CO_FAX] <= i_req.first_at_x;
            r1_orig[cpo_pkg::CO_FAY] <= i_req.first_at_y;
            r1_orig[cpo_pkg::CO_SAX] <= i_req.second_at_x;
            r1_orig[cpo_pkg::CO_SAY] <= i_req.second_at_y;
            r1_d[cpo_pkg::LN_GX] <= DIFF_W'(i_req.first_goal_x) - DIFF_W'(i_req.second_goal_x);
            r1_d[cpo_pkg::LN_GY] <= DIFF_W'(i_req.first_goal_y) - DIFF_W'(i_req.second_goal_y);
            r1_d[cpo_pkg::LN_AX] <= DIFF_W'(i_req.first_at_x) - DIFF_W'(i_req.second_at_x);
            r1_d[cpo_pkg::LN_AY] <= DIFF_W'(i_req.first_at_y) - DIFF_W'(i_req.second_at_y);

            r2_side.orig   <= r1_orig;
            r2_side.ovl_g  <= 1'b0;
            r2_side.ovl_a  <= 1'b0;
            r2_side.near_g <= 1'b0;
            r2_side.near_a <= 1'b0;
            r2_side.zero_a <= 1'b0;
            for (int l = 0; l < 4; l++) begin
                r2_side.neg[l]  <= r1_d[l][DIFF_W-1];
                r2_side.dmag[l] <= r1_d[l][DIFF_W-1] ? (DIFF_W'(0) - r1_d[l]) : r1_d[l];
            end

            r3_side <= r2_side;
            r3_sep2 <= r_sep * r_sep;
            for (int l = 0; l < 4; l++) begin
                r3_sq[l] <= SQ_W'(r2_side.dmag[l]) * SQ_W'(r2_side.dmag[l]);
            end

            r4_side <= r3_side;
            r4_sep2 <= r3_sep2;
            r4_s[cpo_pkg::PS_GOAL] <= r3_sq[cpo_pkg::LN_GX] + r3_sq[cpo_pkg::LN_GY];
            r4_s[cpo_pkg::PS_AT]   <= r3_sq[cpo_pkg::LN_AX] + r3_sq[cpo_pkg::LN_AY];

            r5_side.orig   <= r4_side.orig;
            r5_side.dmag   <= r4_side.dmag;
            r5_side.neg    <= r4_side.neg;
            r5_s           <= r4_s;
            r5_side.ovl_g  <= r4_s[cpo_pkg::PS_GOAL] < SQ_W'(r4_sep2);
            r5_side.ovl_a  <= r4_s[cpo_pkg::PS_AT] < SQ_W'(r4_sep2);
            r5_side.near_g <= 64'(r4_s[cpo_pkg::PS_GOAL]) <= NEAR_LIMIT;
            r5_side.near_a <= 64'(r4_s[cpo_pkg::PS_AT]) <= NEAR_LIMIT;
            r5_side.zero_a <= r4_s[cpo_pkg::PS_AT] == '0;
        end
    end

    // Roots of both squared distances.
    cpo_isqrt #(
        .IN_W   (SQ_W),
        .SIDE_W (SQS_W),
        .LANES  (2)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_v5),
        .i_side  (r5_side),
        .i_rad   (r5_s),
        .o_vld   (w_sq_vld),
        .o_side  (w_sq_side_bits),
        .o_root  (w_root)
    );

    assign w_sq_side = w_sq_side_bits;

    // Stage six: choose the direction source and the shortfall of each pass.
    always_comb begin
        n6_side.orig    = w_sq_side.orig;
        n6_side.ovl_g   = w_sq_side.ovl_g;
        n6_side.ovl_a   = w_sq_side.ovl_a;
        n6_side.plusx_g = w_sq_side.near_g && w_sq_side.zero_a;
        n6_side.plusx_a = w_sq_side.near_a;
        n6_side.sf[cpo_pkg::PS_GOAL] = r_sep - w_root[cpo_pkg::PS_GOAL][SEP_W-1:0];
        n6_side.sf[cpo_pkg::PS_AT]   = r_sep - w_root[cpo_pkg::PS_AT][SEP_W-1:0];
        n6_side.neg[cpo_pkg::LN_AX]  = w_sq_side.neg[cpo_pkg::LN_AX];
        n6_side.neg[cpo_pkg::LN_AY]  = w_sq_side.neg[cpo_pkg::LN_AY];
        n6_mag[cpo_pkg::LN_AX]       = w_sq_side.dmag[cpo_pkg::LN_AX];
        n6_mag[cpo_pkg::LN_AY]       = w_sq_side.dmag[cpo_pkg::LN_AY];
        n6_r[cpo_pkg::PS_AT]         = w_root[cpo_pkg::PS_AT];
        // Coincident targets take their direction from the positions.
        if (w_sq_side.near_g) begin
            n6_side.neg[cpo_pkg::LN_GX] = w_sq_side.neg[cpo_pkg::LN_AX];
            n6_side.neg[cpo_pkg::LN_GY] = w_sq_side.neg[cpo_pkg::LN_AY];
            n6_mag[cpo_pkg::LN_GX]      = w_sq_side.dmag[cpo_pkg::LN_AX];
            n6_mag[cpo_pkg::LN_GY]      = w_sq_side.dmag[cpo_pkg::LN_AY];
            n6_r[cpo_pkg::PS_GOAL]      = w_root[cpo_pkg::PS_AT];
        end else begin
            n6_side.neg[cpo_pkg::LN_GX] = w_sq_side.neg[cpo_pkg::LN_GX];
            n6_side.neg[cpo_pkg::LN_GY] = w_sq_side.neg[cpo_pkg::LN_GY];
            n6_mag[cpo_pkg::LN_GX]      = w_sq_side.dmag[cpo_pkg::LN_GX];
            n6_mag[cpo_pkg::LN_GY]      = w_sq_side.dmag[cpo_pkg::LN_GY];
            n6_r[cpo_pkg::PS_GOAL]      = w_root[cpo_pkg::PS_GOAL];
        end
    end

    // Stages six to eight: products, rounding term and divisor.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_side <= n6_side;
            r6_mag  <= n6_mag;
            r6_r    <= n6_r;

            r7_side <= r6_side;
            r7_r    <= r6_r;
            for (int l = 0; l < 4; l++) begin
                r7_prod[l] <= PROD_W'(r6_mag[l]) * PROD_W'(r6_side.sf[l/2]);
            end

            r8_side <= r7_side;
            for (int l = 0; l < 4; l++) begin
                r8_num[l] <= NUM_W'(r7_prod[l]) + NUM_W'(r7_r[l/2]);
                r8_den[l] <= {r7_r[l/2], 1'b0};
            end
        end
    end

    // Rounded moves along each axis.
    cpo_div #(
        .DEN_W  (DEN_W),
        .Q_W    (Q_W),
        .SIDE_W (DVS_W),
        .LANES  (4)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_v8),
        .i_side  (r8_side),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side_bits),
        .o_quo   (w_quo)
    );

    assign w_dv_side = w_dv_side_bits;

    // Stage nine: signed move of each lane, zero without overlap, or the plus-x fallback.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            logic ovl;
            logic plusx;
            ovl   = (l < 2) ? w_dv_side.ovl_g : w_dv_side.ovl_a;
            plusx = (l < 2) ? w_dv_side.plusx_g : w_dv_side.plusx_a;
            if (!ovl) begin
                n9_mv[l] = '0;
            end else if (plusx) begin
                n9_mv[l] = ((l % 2) == 0) ? ((MV_W'(w_dv_side.sf[l/2]) + MV_W'(1)) >> 1) : '0;
            end else if (w_dv_side.neg[l]) begin
                n9_mv[l] = MV_W'(0) - MV_W'(w_quo[l]);
            end else begin
                n9_mv[l] = MV_W'(w_quo[l]);
            end
        end
    end

    // Stage ten: apply the moves and saturate.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            logic signed [COORD_W:0] mv;
            int fi;
            int si;
            mv = (COORD_W+1)'($signed(r9_mv[l]));
            fi = (l < 2) ? l : l + 2;
            si = fi + 2;
            n10_out[fi] = cpo_pkg::sat_coord((COORD_W+1)'($signed(r9_orig[fi])) + mv);
            n10_out[si] = cpo_pkg::sat_coord((COORD_W+1)'($signed(r9_orig[si])) - mv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_orig <= w_dv_side.orig;
            r9_mv   <= n9_mv;
            r10_out <= n10_out;
        end
    end

    // Result channel.
    assign o_res.valid             = r_v10;
    assign o_res.new_first_goal_x  = r10_out[cpo_pkg::CO_FGX];
    assign o_res.new_first_goal_y  = r10_out[cpo_pkg::CO_FGY];
    assign o_res.new_second_goal_x = r10_out[cpo_pkg::CO_SGX];
    assign o_res.new_second_goal_y = r10_out[cpo_pkg::CO_SGY];
    assign o_res.new_first_at_x    = r10_out[cpo_pkg::CO_FAX];
    assign o_res.new_first_at_y    = r10_out[cpo_pkg::CO_FAY];
    assign o_res.new_second_at_x   = r10_out[cpo_pkg::CO_SAX];
    assign o_res.new_second_at_y   = r10_out[cpo_pkg::CO_SAY];

endmodule

`default_nettype wire

// ===== sv/cpo_isqrt.sv =====
`default_nettype none

// Pipelined integer square root, one result bit per stage, several lanes in step.
module cpo_isqrt #(
    parameter int IN_W   = 42,
    parameter int SIDE_W = 1,
    parameter int LANES  = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic                             i_vld,
    input  wire logic [SIDE_W-1:0]                i_side,
    input  wire logic [LANES-1:0][IN_W-1:0]       i_rad,
    output logic                                  o_vld,
    output logic [SIDE_W-1:0]                     o_side,
    output logic [LANES-1:0][IN_W/2-1:0]          o_root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int STEPS  = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic                           r_vld  [STEPS];
    logic [SIDE_W-1:0]              r_side [STEPS];
    logic [LANES-1:0][IN_W-1:0]     r_rad  [STEPS];
    logic [LANES-1:0][REM_W-1:0]    r_rem  [STEPS];
    logic [LANES-1:0][ROOT_W-1:0]   r_root [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic                         w_vld;
        logic [SIDE_W-1:0]            w_side;
        logic [LANES-1:0][IN_W-1:0]   w_rad;
        logic [LANES-1:0][REM_W-1:0]  w_rem;
        logic [LANES-1:0][ROOT_W-1:0] w_root;
        logic [LANES-1:0][REM_W-1:0]  w_trial;
        logic [LANES-1:0][REM_W-1:0]  w_test;
        logic [LANES-1:0][IN_W-1:0]   n_rad;
        logic [LANES-1:0][REM_W-1:0]  n_rem;
        logic [LANES-1:0][ROOT_W-1:0] n_root;

        // The first step starts from the radicand with an empty root.
        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_side = r_side[g-1];
            assign w_rad  = r_rad[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_trial[l] = {w_rem[l][REM_W-3:0], w_rad[l][IN_W-1 -: 2]};
                w_test[l]  = {w_root[l], 2'b01};
                n_rad[l]   = w_rad[l] << 2;
                if (w_trial[l] >= w_test[l]) begin
                    n_rem[l]  = w_trial[l] - w_test[l];
                    n_root[l] = {w_root[l][ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem[l]  = w_trial[l];
                    n_root[l] = {w_root[l][ROOT_W-2:0], 1'b0};
                end
            end
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_adv) begin
                r_vld[g] <= w_vld;
            end
        end

        // Payload of the stage.
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[g] <= w_side;
                r_rad[g]  <= n_rad;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_side = r_side[STEPS-1];
    assign o_root = r_root[STEPS-1];

endmodule

`default_nettype wire

// ===== sv/cpo_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage; the quotient must fit Q_W bits.
module cpo_div #(
    parameter int DEN_W  = 22,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1,
    parameter int LANES  = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_adv,
    input  wire logic                              i_vld,
    input  wire logic [SIDE_W-1:0]                 i_side,
    input  wire logic [LANES-1:0][DEN_W+Q_W-1:0]   i_num,
    input  wire logic [LANES-1:0][DEN_W-1:0]       i_den,
    output logic                                   o_vld,
    output logic [SIDE_W-1:0]                      o_side,
    output logic [LANES-1:0][Q_W-1:0]              o_quo
);

    localparam int NUM_W = DEN_W + Q_W;

    logic                          r_vld  [Q_W];
    logic [SIDE_W-1:0]             r_side [Q_W];
    logic [LANES-1:0][NUM_W-1:0]   r_rem  [Q_W];
    logic [LANES-1:0][DEN_W-1:0]   r_den  [Q_W];
    logic [LANES-1:0][Q_W-1:0]     r_quo  [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_step
        logic                        w_vld;
        logic [SIDE_W-1:0]           w_side;
        logic [LANES-1:0][NUM_W-1:0] w_rem;
        logic [LANES-1:0][DEN_W-1:0] w_den;
        logic [LANES-1:0][Q_W-1:0]   w_quo;
        logic [LANES-1:0][NUM_W-1:0] w_shd;
        logic [LANES-1:0][NUM_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_quo;

        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_side = r_side[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_quo  = r_quo[g-1];
        end

        // Subtract the divisor at this bit weight when it fits.
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_shd[l] = {{Q_W{1'b0}}, w_den[l]} << (Q_W - 1 - g);
                if (w_rem[l] >= w_shd[l]) begin
                    n_rem[l] = w_rem[l] - w_shd[l];
                    n_quo[l] = {w_quo[l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_rem[l];
                    n_quo[l] = {w_quo[l][Q_W-2:0], 1'b0};
                end
            end
        end

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_adv) begin
                r_vld[g] <= w_vld;
            end
        end

        // Payload of the stage.
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[g] <= w_side;
                r_rem[g]  <= n_rem;
                r_den[g]  <= w_den;
                r_quo[g]  <= n_quo;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    logic i_clk;
    logic i_rst_n;

    cpo_req_if req_if ();
    cpo_res_if res_if ();
    cpo_cfg_if cfg_if ();

    circle_pair_overlap_separation uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    typedef struct packed {
        cpo_pkg::t_coord [7:0] c;
    } t_pair;

    localparam int LATENCY = 46;

    t_pair  pending_pairs[$];
    t_pair  separated_pairs[$];
    logic [cpo_pkg::SEP_W-1:0] sep_value;

    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off_cycles;
    bit     hold_off_armed;
    bit     hold_off_taken;
    int     n_errors;
    int     n_sent;
    int     n_checked;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor.
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Move along one axis, rounded to nearest with ties away from zero.
    function automatic longint axis_move(input longint d, input longint unsigned sf,
                                         input longint unsigned r);
        longint unsigned m;
        longint unsigned q;
        m = (d < 0) ? -d : d;
        q = (m * sf + r) / (2 * r);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic cpo_pkg::t_coord clamp_coord(input longint v);
        if (v > 524287) return cpo_pkg::COORD_MAX;
        if (v < -524288) return cpo_pkg::COORD_MIN;
        return cpo_pkg::t_coord'(v);
    endfunction

    // Push one pair of points apart; alt gives the fallback direction.
    function automatic void push_apart(inout longint p[4], input longint alt[4],
                                       input bit use_alt);
        longint dx, dy, ax, ay, mx, my;
        longint unsigned s, as_, sep, sf, r;
        dx = p[0] - p[2];
        dy = p[1] - p[3];
        s = dx * dx + dy * dy;
        sep = sep_value;
        if (!(s < sep * sep)) return;
        sf = sep - root_floor(s);
        if (!(s * 1000000 <= (64'd1 << (2 * cpo_pkg::COORD_FRAC_BITS_DEF)))) begin
            r = root_floor(s);
            mx = axis_move(dx, sf, r);
            my = axis_move(dy, sf, r);
        end else begin
            ax = 0;
            ay = 0;
            as_ = 0;
            if (use_alt) begin
                ax = alt[0] - alt[2];
                ay = alt[1] - alt[3];
                as_ = ax * ax + ay * ay;
            end
            if (as_ != 0) begin
                r = root_floor(as_);
                mx = axis_move(ax, sf, r);
                my = axis_move(ay, sf, r);
            end else begin
                mx = longint'((sf + 1) / 2);
                my = 0;
            end
        end
        p[0] += mx;
        p[1] += my;
        p[2] -= mx;
        p[3] -= my;
    endfunction

    function automatic t_pair separate_pair(input t_pair x);
        longint g[4];
        longint a[4];
        longint dummy[4];
        t_pair y;
        for (int i = 0; i < 4; i++) begin
            g[i] = x.c[i];
            a[i] = x.c[4+i];
            dummy[i] = 0;
        end
        push_apart(g, a, 1'b1);
        push_apart(a, dummy, 1'b0);
        for (int i = 0; i < 4; i++) begin
            y.c[i] = clamp_coord(g[i]);
            y.c[4+i] = clamp_coord(a[i]);
        end
        return y;
    endfunction

    function automatic cpo_pkg::t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return cpo_pkg::COORD_MAX;
            1: return cpo_pkg::COORD_MIN;
            2: return cpo_pkg::t_coord'($urandom);
            default: return cpo_pkg::t_coord'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    // Offset of up to half the spread either way.
    function automatic cpo_pkg::t_coord rand_offset(input int spread);
        return cpo_pkg::t_coord'($signed($urandom_range(0, spread)) - spread / 2);
    endfunction

    // Pairs mostly near one another, so that separation actually happens.
    function automatic t_pair rand_pair();
        t_pair p;
        int spread;
        spread = (sep_value == 0) ? 64 : int'(sep_value) * 2;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 8; i++) p.c[i] = rand_coord();
        end else begin
            p.c[cpo_pkg::CO_FGX] = rand_coord();
            p.c[cpo_pkg::CO_FGY] = rand_coord();
            p.c[cpo_pkg::CO_FAX] = rand_coord();
            p.c[cpo_pkg::CO_FAY] = rand_coord();
            p.c[cpo_pkg::CO_SGX] = p.c[cpo_pkg::CO_FGX] + rand_offset(spread);
            p.c[cpo_pkg::CO_SGY] = p.c[cpo_pkg::CO_FGY] + rand_offset(spread);
            p.c[cpo_pkg::CO_SAX] = p.c[cpo_pkg::CO_FAX] + rand_offset(spread);
            p.c[cpo_pkg::CO_SAY] = p.c[cpo_pkg::CO_FAY] + rand_offset(spread);
            if ($urandom_range(0, 7) == 0) begin
                p.c[cpo_pkg::CO_SGX] = p.c[cpo_pkg::CO_FGX];
                p.c[cpo_pkg::CO_SGY] = p.c[cpo_pkg::CO_FGY];
            end
            if ($urandom_range(0, 9) == 0) begin
                p.c[cpo_pkg::CO_SAX] = p.c[cpo_pkg::CO_FAX];
                p.c[cpo_pkg::CO_SAY] = p.c[cpo_pkg::CO_FAY];
            end
        end
        return p;
    endfunction

    function automatic t_pair make_pair(input int fgx, fgy, sgx, sgy, fax, fay, sax, say);
        t_pair p;
        p.c[cpo_pkg::CO_FGX] = cpo_pkg::t_coord'(fgx);
        p.c[cpo_pkg::CO_FGY] = cpo_pkg::t_coord'(fgy);
        p.c[cpo_pkg::CO_SGX] = cpo_pkg::t_coord'(sgx);
        p.c[cpo_pkg::CO_SGY] = cpo_pkg::t_coord'(sgy);
        p.c[cpo_pkg::CO_FAX] = cpo_pkg::t_coord'(fax);
        p.c[cpo_pkg::CO_FAY] = cpo_pkg::t_coord'(fay);
        p.c[cpo_pkg::CO_SAX] = cpo_pkg::t_coord'(sax);
        p.c[cpo_pkg::CO_SAY] = cpo_pkg::t_coord'(say);
        return p;
    endfunction

    // Append a request to the pending queue.
    task automatic queue_pair(input t_pair p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    // Request driver; each accepted request leaves its expected result behind.
    always @(posedge i_clk) begin
        t_pair cur;
        t_pair seen;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                seen.c[cpo_pkg::CO_FGX] = req_if.first_goal_x;
                seen.c[cpo_pkg::CO_FGY] = req_if.first_goal_y;
                seen.c[cpo_pkg::CO_SGX] = req_if.second_goal_x;
                seen.c[cpo_pkg::CO_SGY] = req_if.second_goal_y;
                seen.c[cpo_pkg::CO_FAX] = req_if.first_at_x;
                seen.c[cpo_pkg::CO_FAY] = req_if.first_at_y;
                seen.c[cpo_pkg::CO_SAX] = req_if.second_at_x;
                seen.c[cpo_pkg::CO_SAY] = req_if.second_at_y;
                separated_pairs.insert(separated_pairs.size(), separate_pair(seen));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur = pending_pairs.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.first_goal_x  <= cur.c[cpo_pkg::CO_FGX];
                    req_if.first_goal_y  <= cur.c[cpo_pkg::CO_FGY];
                    req_if.second_goal_x <= cur.c[cpo_pkg::CO_SGX];
                    req_if.second_goal_y <= cur.c[cpo_pkg::CO_SGY];
                    req_if.first_at_x    <= cur.c[cpo_pkg::CO_FAX];
                    req_if.first_at_y    <= cur.c[cpo_pkg::CO_FAY];
                    req_if.second_at_x   <= cur.c[cpo_pkg::CO_SAX];
                    req_if.second_at_y   <= cur.c[cpo_pkg::CO_SAY];
                    n_sent <= n_sent + 1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once by the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_cycles <= 0;
            hold_off_taken  <= 1'b0;
        end else if (hold_off_armed && !hold_off_taken) begin
            hold_off_cycles <= 200;
            hold_off_taken  <= 1'b1;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_pair got;
        t_pair want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.c[cpo_pkg::CO_FGX] = res_if.new_first_goal_x;
                got.c[cpo_pkg::CO_FGY] = res_if.new_first_goal_y;
                got.c[cpo_pkg::CO_SGX] = res_if.new_second_goal_x;
                got.c[cpo_pkg::CO_SGY] = res_if.new_second_goal_y;
                got.c[cpo_pkg::CO_FAX] = res_if.new_first_at_x;
                got.c[cpo_pkg::CO_FAY] = res_if.new_first_at_y;
                got.c[cpo_pkg::CO_SAX] = res_if.new_second_at_x;
                got.c[cpo_pkg::CO_SAY] = res_if.new_second_at_y;
                if (separated_pairs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    n_errors = n_errors + 1;
                end else begin
                    want = separated_pairs.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        if (got.c[i] !== want.c[i]) begin
                            $display("%0t: coordinate %0d expected %0d actual %0d",
                                     $time, i, want.c[i], got.c[i]);
                            n_errors = n_errors + 1;
                        end
                    end
                    n_checked = n_checked + 1;
                end
            end
            if (hold_off_cycles > 0) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Wait until every queued request has been sent and its result taken.
    task automatic drain();
        while (pending_pairs.size() != 0 || req_if.valid || separated_pairs.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Register write while the pipeline is empty.
    task automatic write_separation(input logic [cpo_pkg::SEP_W-1:0] v);
        drain();
        cfg_if.valid          <= 1'b1;
        cfg_if.min_separation <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sep_value = v;
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) queue_pair(rand_pair());
    endtask

    // Stimulus and end of run.
    initial begin
        logic [cpo_pkg::SEP_W-1:0] sep_list[6];
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        send_idle_pct = 31;
        recv_idle_pct = 71;
        hold_off_armed = 1'b0;
        sep_value = cpo_pkg::SEP_RESET;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.min_separation = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases at the reset separation.
        queue_pair(make_pair(0, 0, 100, 0, 0, 0, 0, 100));
        queue_pair(make_pair(0, 0, 0, 0, 50, 0, 0, 30));
        queue_pair(make_pair(500, 500, 500, 500, 7, 7, 7, 7));
        queue_pair(make_pair(10, 10, 10, 10, 3, 4, 3, 4));
        queue_pair(make_pair(0, 0, 0, 1, 0, 0, 0, 0));
        queue_pair(make_pair(524287, 524287, 524287, 524287, 524287, 0, 524280, 0));
        queue_pair(make_pair(-524288, -524288, -524288, -524288, -524288, 5, -524280, 5));
        queue_pair(make_pair(524287, -524288, -524288, 524287,
                             -524288, 524287, 524287, -524288));
        queue_pair(make_pair(-300, 200, 300, -200, -1, -1, 1, 1));
        queue_pair(make_pair(0, 0, 10239, 0, 0, 0, 10240, 0));
        queue_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        drain();

        // Random phases over several separations, extremes included.
        sep_list[0] = 16'd0;
        sep_list[1] = 16'd65535;
        sep_list[2] = 16'd1;
        sep_list[3] = 16'd300;
        sep_list[4] = 16'd10240;
        sep_list[5] = 16'd2048;
        for (int k = 0; k < 6; k++) begin
            write_separation(sep_list[k]);
            if (k == 1) queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
            queue_random(35);
            drain();
        end

        // Idling pattern sweep.
        queue_random(140);
        drain();
        send_idle_pct = 71;
        recv_idle_pct = 31;
        queue_random(140);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(150);
        hold_off_armed = 1'b1;
        drain();

        $display("tb: %0d requests sent, %0d results checked over 6 separations", n_sent,
                 n_checked);
        $display("tb: covered coincident targets, coincident positions, saturation and a full stall");
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
